// ===== rtl/core/tcg_pkg.sv =====
// ----------------------------------------------------------------------------
// tcg_pkg
// Codes, constants, glyph tables and result type of the typewriter code to
// glyph translator with carriage tracking.
// ----------------------------------------------------------------------------
package tcg_pkg;

   localparam int CODE_W  = 6;
   localparam int COL_W   = 8;
   localparam int GLYPH_W = 8;

   localparam int TAB_PITCH = 8;

   localparam logic [CODE_W-1:0] CODE_COLOR = 6'o20;
   localparam logic [CODE_W-1:0] CODE_BS    = 6'o43;
   localparam logic [CODE_W-1:0] CODE_TAB   = 6'o45;
   localparam logic [CODE_W-1:0] CODE_CR    = 6'o51;
   localparam logic [CODE_W-1:0] CODE_STOP  = 6'o61;
   localparam logic [CODE_W-1:0] CODE_UPPER = 6'o71;
   localparam logic [CODE_W-1:0] CODE_LOWER = 6'o75;
   localparam logic [CODE_W-1:0] CODE_DEL   = 6'o77;

   localparam logic [COL_W-1:0] WIDTH_RESET = 8'd80;
   localparam logic [COL_W-1:0] COL_MAX     = 8'd255;

   localparam logic [GLYPH_W-1:0] GLYPH_LOWER [64] = '{
      8'h00, 8'h00, 8'h65, 8'h38, 8'h00, 8'h7C, 8'h61, 8'h33,
      8'h20, 8'h3D, 8'h73, 8'h34, 8'h69, 8'h2B, 8'h75, 8'h32,
      8'h00, 8'h2E, 8'h64, 8'h35, 8'h72, 8'h31, 8'h6A, 8'h37,
      8'h6E, 8'h2C, 8'h66, 8'h36, 8'h63, 8'h2D, 8'h6B, 8'h00,
      8'h74, 8'h00, 8'h7A, 8'h00, 8'h6C, 8'h00, 8'h77, 8'h00,
      8'h68, 8'h00, 8'h79, 8'h00, 8'h70, 8'h00, 8'h71, 8'h00,
      8'h6F, 8'h00, 8'h62, 8'h00, 8'h67, 8'h00, 8'h39, 8'h00,
      8'h6D, 8'h00, 8'h78, 8'h00, 8'h76, 8'h00, 8'h30, 8'h00
   };

   localparam logic [GLYPH_W-1:0] GLYPH_UPPER [64] = '{
      8'h00, 8'h00, 8'h45, 8'h88, 8'h00, 8'h5F, 8'h41, 8'h83,
      8'h20, 8'h3A, 8'h53, 8'h84, 8'h49, 8'h2F, 8'h55, 8'h82,
      8'h00, 8'h29, 8'h44, 8'h85, 8'h52, 8'h81, 8'h4A, 8'h87,
      8'h4E, 8'h28, 8'h46, 8'h86, 8'h43, 8'h8A, 8'h4B, 8'h00,
      8'h54, 8'h00, 8'h5A, 8'h00, 8'h4C, 8'h00, 8'h57, 8'h00,
      8'h48, 8'h00, 8'h59, 8'h00, 8'h50, 8'h00, 8'h51, 8'h00,
      8'h4F, 8'h00, 8'h42, 8'h00, 8'h47, 8'h00, 8'h89, 8'h00,
      8'h4D, 8'h00, 8'h58, 8'h00, 8'h56, 8'h00, 8'h80, 8'h00
   };

   typedef struct packed {
      logic               glyph_valid;
      logic [GLYPH_W-1:0] glyph;
      logic [COL_W-1:0]   glyph_column;
      logic               line_feed;
   } rsp_type;

   function automatic logic [GLYPH_W-1:0] glyph_lookup(input logic upper,
                                                       input logic [CODE_W-1:0] code);
      logic [GLYPH_W-1:0] g;
      g = upper ? GLYPH_UPPER[code] : GLYPH_LOWER[code];
      return g;
   endfunction

endpackage

// ===== rtl/core/typewriter_code_to_glyph_carriage.sv =====
// ----------------------------------------------------------------------------
// typewriter_code_to_glyph_carriage
// Translates six-bit typewriter codes to glyphs, tracking carriage column
// and case; control codes move the carriage, set case or feed a line.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                   | handshake
//  req     | in        | req_code                                | req_valid/req_ready
//  rsp     | out       | rsp_glyph_valid, rsp_glyph,             | rsp_valid/rsp_ready
//          |           | rsp_glyph_column, rsp_line_feed         |
//  csr     | in        | csr_line_width                          | csr_valid/csr_ready
//
//  One code per cycle while req_ready is high; every transfer yields a registered result.
//  Column and case update in the transfer cycle, so codes chain back to back.
//  A two-entry output (result register plus skid register) keeps req_ready
//  high while only the result register is stalled; it drops only when both are full.
//  Synchronous reset: column 0, lower case, line width 80, output empty.
// ----------------------------------------------------------------------------
module typewriter_code_to_glyph_carriage (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [tcg_pkg::CODE_W-1:0]   req_code,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_glyph_valid,
   output logic [tcg_pkg::GLYPH_W-1:0]  rsp_glyph,
   output logic [tcg_pkg::COL_W-1:0]    rsp_glyph_column,
   output logic                         rsp_line_feed,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tcg_pkg::COL_W-1:0]    csr_line_width
);

   logic [tcg_pkg::COL_W-1:0] width_ff;
   logic [tcg_pkg::COL_W-1:0] col_ff, col_in;
   logic                      upper_ff, upper_in;
   tcg_pkg::rsp_type          res_in;
   tcg_pkg::rsp_type          out_ff, skid_ff;
   logic                      out_valid_ff, skid_valid_ff;
   logic                      req_xfer;
   logic [tcg_pkg::COL_W:0]   tab_sum;
   logic [tcg_pkg::COL_W-1:0] print_col;

   assign req_ready = !skid_valid_ff;
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      col_in   = col_ff;
      upper_in = upper_ff;
      res_in   = '0;
      tab_sum  = {1'b0, col_ff} + (tcg_pkg::COL_W+1)'(tcg_pkg::TAB_PITCH)
                 - (tcg_pkg::COL_W+1)'(col_ff % tcg_pkg::TAB_PITCH);
      print_col = (col_ff >= width_ff) ? '0 : col_ff;
      unique case (req_code)
         tcg_pkg::CODE_BS: begin
            if (col_ff != '0) col_in = col_ff - 1'b1;
         end
         tcg_pkg::CODE_TAB: begin
            col_in = tab_sum[tcg_pkg::COL_W] ? tcg_pkg::COL_MAX
                                             : tab_sum[tcg_pkg::COL_W-1:0];
         end
         tcg_pkg::CODE_CR: begin
            col_in           = '0;
            res_in.line_feed = 1'b1;
         end
         tcg_pkg::CODE_UPPER: upper_in = 1'b1;
         tcg_pkg::CODE_LOWER: upper_in = 1'b0;
         tcg_pkg::CODE_COLOR, tcg_pkg::CODE_STOP, tcg_pkg::CODE_DEL: begin
         end
         default: begin
            res_in.line_feed    = (col_ff >= width_ff);
            res_in.glyph_valid  = 1'b1;
            res_in.glyph        = tcg_pkg::glyph_lookup(upper_ff, req_code);
            res_in.glyph_column = print_col;
            col_in = (print_col == tcg_pkg::COL_MAX) ? print_col : print_col + 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= tcg_pkg::WIDTH_RESET;
         col_ff        <= '0;
         upper_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) width_ff <= csr_line_width;
         if (req_xfer) begin
            col_ff   <= col_in;
            upper_ff <= upper_in;
         end
         if (rsp_ready || !out_valid_ff) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= req_xfer;
            end
         end else if (req_xfer) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready || !out_valid_ff) begin
         if (skid_valid_ff) out_ff <= skid_ff;
         else if (req_xfer) out_ff <= res_in;
      end else if (req_xfer) begin
         skid_ff <= res_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_glyph_valid  = out_ff.glyph_valid;
   assign rsp_glyph        = out_ff.glyph;
   assign rsp_glyph_column = out_ff.glyph_column;
   assign rsp_line_feed    = out_ff.line_feed;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty result register");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      req_xfer && out_valid_ff && !rsp_ready |=> skid_valid_ff)
      else $error("transfer during output stall not captured");

   a_control_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_glyph_valid |-> rsp_glyph == '0 && rsp_glyph_column == '0)
      else $error("control code result carries glyph data");

endmodule
